// ===== src/sef_pkg.sv =====
// Package for the sticky edge cursor filter: widths, register map and shared types.
`default_nettype none
package sef_pkg;

  localparam int COORD_BITS = 16;
  localparam int PUSH_BITS  = 18;
  localparam int HOLD_FORCE = 514;
  localparam int NUM_REGS   = 8;
  localparam int DATA_BITS  = 32;
  localparam int ADDR_BITS  = $clog2(NUM_REGS) + 2;
  localparam int IDX_BITS   = $clog2(NUM_REGS);
  localparam int WIDE_BITS  = (COORD_BITS > PUSH_BITS) ? COORD_BITS : PUSH_BITS;
  localparam int SUM_BITS   = WIDE_BITS + 1;
  localparam int REL_BITS   = WIDE_BITS + 2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [PUSH_BITS-1:0]         push_t;

  typedef enum logic [IDX_BITS-1:0] {
    REG_PRI_LEFT,
    REG_PRI_TOP,
    REG_PRI_RIGHT,
    REG_PRI_BOTTOM,
    REG_DESK_LEFT,
    REG_DESK_TOP,
    REG_DESK_RIGHT,
    REG_DESK_BOTTOM
  } reg_idx_t;

  typedef struct packed {
    coord_t pri_left;
    coord_t pri_top;
    coord_t pri_right;
    coord_t pri_bottom;
    coord_t desk_left;
    coord_t desk_top;
    coord_t desk_right;
    coord_t desk_bottom;
  } cfg_t;

  typedef struct packed {
    coord_t new_x;
    coord_t new_y;
    logic   free_key;
  } move_t;

  typedef struct packed {
    logic   override;
    coord_t cursor_x;
    coord_t cursor_y;
    logic   pinned;
  } result_t;

  typedef struct packed {
    coord_t last_x;
    coord_t last_y;
    logic   held;
    coord_t edge_x;
    coord_t edge_y;
    logic   side_edge;
    push_t  push_total;
  } state_t;

endpackage
`default_nettype wire

// ===== src/sef_if.sv =====
// Request channel interfaces for pointer moves and filtered cursor results.
`default_nettype none
interface sef_in_if;
  import sef_pkg::*;
  logic   valid;
  logic   ready;
  coord_t new_x;
  coord_t new_y;
  logic   free_key;
  modport source (output valid, output new_x, output new_y, output free_key, input ready);
  modport sink (input valid, input new_x, input new_y, input free_key, output ready);
endinterface

interface sef_out_if;
  import sef_pkg::*;
  logic   valid;
  logic   ready;
  logic   override;
  coord_t cursor_x;
  coord_t cursor_y;
  logic   pinned;
  modport source (output valid, output override, output cursor_x, output cursor_y,
                  output pinned, input ready);
  modport sink (input valid, input override, input cursor_x, input cursor_y,
                input pinned, output ready);
endinterface
`default_nettype wire

// ===== src/sef_regs.sv =====
// APB-style register file holding the primary and desktop rectangle edges.
`default_nettype none
module sef_regs (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [sef_pkg::ADDR_BITS-1:0] paddr,
  input  wire logic [sef_pkg::DATA_BITS-1:0] pwdata,
  output logic      [sef_pkg::DATA_BITS-1:0] prdata,
  output logic                             pready,
  output sef_pkg::cfg_t                    cfg
);
  import sef_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  coord_t   wval;
  coord_t   rval;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_BITS-1:2]);
  assign wval   = coord_t'(pwdata[COORD_BITS-1:0]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_PRI_LEFT:    cfg_r.pri_left    <= wval;
        REG_PRI_TOP:     cfg_r.pri_top     <= wval;
        REG_PRI_RIGHT:   cfg_r.pri_right   <= wval;
        REG_PRI_BOTTOM:  cfg_r.pri_bottom  <= wval;
        REG_DESK_LEFT:   cfg_r.desk_left   <= wval;
        REG_DESK_TOP:    cfg_r.desk_top    <= wval;
        REG_DESK_RIGHT:  cfg_r.desk_right  <= wval;
        REG_DESK_BOTTOM: cfg_r.desk_bottom <= wval;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PRI_LEFT:    rval = cfg_r.pri_left;
      REG_PRI_TOP:     rval = cfg_r.pri_top;
      REG_PRI_RIGHT:   rval = cfg_r.pri_right;
      REG_PRI_BOTTOM:  rval = cfg_r.pri_bottom;
      REG_DESK_LEFT:   rval = cfg_r.desk_left;
      REG_DESK_TOP:    rval = cfg_r.desk_top;
      REG_DESK_RIGHT:  rval = cfg_r.desk_right;
      REG_DESK_BOTTOM: rval = cfg_r.desk_bottom;
      default:         rval = '0;
    endcase
  end

  // Reads return the register sign-extended to the bus width.
  assign prdata = DATA_BITS'(rval);

endmodule
`default_nettype wire

// ===== src/sef_step.sv =====
// Combinational decision for one pointer move: pin, accumulate, release or pass.
`default_nettype none
module sef_step (
  input  sef_pkg::cfg_t    cfg,
  input  sef_pkg::move_t   mv,
  input  sef_pkg::state_t  st,
  output sef_pkg::result_t res,
  output sef_pkg::state_t  st_nxt
);
  import sef_pkg::*;

  localparam coord_t C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam logic signed [REL_BITS-1:0] C_MAX_E = REL_BITS'(C_MAX);
  localparam logic signed [REL_BITS-1:0] C_MIN_E = REL_BITS'(C_MIN);
  localparam push_t PUSH_MAX = '1;

  function automatic logic in_rect(input cfg_t c, input coord_t x, input coord_t y);
    in_rect = (x >= c.pri_left) && (x < c.pri_right) && (y >= c.pri_top) && (y < c.pri_bottom);
  endfunction

  function automatic coord_t clamp_edge(input coord_t v, input coord_t lo, input coord_t hi_ex);
    logic signed [COORD_BITS:0] v_e;
    logic signed [COORD_BITS:0] lo_e;
    logic signed [COORD_BITS:0] hi_e;
    logic signed [COORD_BITS:0] r;
    v_e  = (COORD_BITS+1)'(v);
    lo_e = (COORD_BITS+1)'(lo);
    hi_e = (COORD_BITS+1)'(hi_ex) - (COORD_BITS+1)'(1);
    r    = (v_e > hi_e) ? hi_e : v_e;
    if (r < lo_e) begin
      r = lo_e;
    end
    clamp_edge = r[COORD_BITS-1:0];
  endfunction

  logic                        prev_in, new_in, fric, side_new;
  logic signed [COORD_BITS:0]  diff, diff_neg;
  logic [COORD_BITS-1:0]       mag;
  logic [SUM_BITS-1:0]         sum;
  push_t                       push_sat, over;
  logic                        release_now, beyond;
  logic signed [REL_BITS-1:0]  base, over_e, moved;
  coord_t                      rel_coord;
  coord_t                      pin_x, pin_y;

  assign prev_in  = in_rect(cfg, st.last_x, st.last_y);
  assign new_in   = in_rect(cfg, mv.new_x, mv.new_y);
  assign side_new = (mv.new_x < cfg.pri_left) || (mv.new_x >= cfg.pri_right);

  // The crossed edge, checked left, right, top, bottom in that order, decides whether the desktop carries on beyond it.
  always_comb begin
    if (mv.new_x < cfg.pri_left) begin
      fric = cfg.desk_left < cfg.pri_left;
    end else if (mv.new_x >= cfg.pri_right) begin
      fric = cfg.desk_right > cfg.pri_right;
    end else if (mv.new_y < cfg.pri_top) begin
      fric = cfg.desk_top < cfg.pri_top;
    end else if (mv.new_y >= cfg.pri_bottom) begin
      fric = cfg.desk_bottom > cfg.pri_bottom;
    end else begin
      fric = 1'b0;
    end
  end

  assign pin_x = clamp_edge(mv.new_x, cfg.pri_left, cfg.pri_right);
  assign pin_y = clamp_edge(mv.new_y, cfg.pri_top, cfg.pri_bottom);

  // Push past the pinned point along the crossing axis, saturating.
  assign diff     = st.side_edge ?
                    ((COORD_BITS+1)'(mv.new_x) - (COORD_BITS+1)'(st.edge_x)) :
                    ((COORD_BITS+1)'(mv.new_y) - (COORD_BITS+1)'(st.edge_y));
  assign diff_neg = -diff;
  assign mag      = diff[COORD_BITS] ? diff_neg[COORD_BITS-1:0] : diff[COORD_BITS-1:0];
  assign sum      = SUM_BITS'(st.push_total) + SUM_BITS'(mag);
  assign push_sat = (sum > SUM_BITS'(PUSH_MAX)) ? PUSH_MAX : sum[PUSH_BITS-1:0];
  assign release_now = push_sat >= PUSH_BITS'(HOLD_FORCE);
  assign over     = push_sat - PUSH_BITS'(HOLD_FORCE);

  assign beyond = st.side_edge ? (mv.new_x > st.edge_x) : (mv.new_y > st.edge_y);
  assign base   = st.side_edge ? REL_BITS'(st.edge_x) : REL_BITS'(st.edge_y);
  assign over_e = $signed(REL_BITS'(over));
  assign moved  = beyond ? (base + over_e) : (base - over_e);

  always_comb begin
    if (moved > C_MAX_E) begin
      rel_coord = C_MAX;
    end else if (moved < C_MIN_E) begin
      rel_coord = C_MIN;
    end else begin
      rel_coord = moved[COORD_BITS-1:0];
    end
  end

  always_comb begin
    st_nxt        = st;
    st_nxt.last_x = mv.new_x;
    st_nxt.last_y = mv.new_y;
    res.override  = 1'b0;
    res.cursor_x  = mv.new_x;
    res.cursor_y  = mv.new_y;
    res.pinned    = 1'b0;
    if (st.held) begin
      if (mv.free_key) begin
        st_nxt.held = 1'b0;
      end else if (new_in) begin
        st_nxt.held       = 1'b0;
        st_nxt.push_total = '0;
      end else begin
        res.override = 1'b1;
        res.cursor_x = st.edge_x;
        res.cursor_y = st.edge_y;
        if (release_now) begin
          if (st.side_edge) begin
            res.cursor_x = rel_coord;
          end else begin
            res.cursor_y = rel_coord;
          end
          st_nxt.held       = 1'b0;
          st_nxt.push_total = '0;
        end else begin
          st_nxt.push_total = push_sat;
          res.pinned        = 1'b1;
        end
      end
    end else if (!mv.free_key && prev_in && !new_in && fric) begin
      st_nxt.held       = 1'b1;
      st_nxt.push_total = '0;
      st_nxt.side_edge  = side_new;
      st_nxt.edge_x     = pin_x;
      st_nxt.edge_y     = pin_y;
      res.override      = 1'b1;
      res.cursor_x      = pin_x;
      res.cursor_y      = pin_y;
      res.pinned        = 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== src/sticky_edge_cursor_filter.sv =====
// Top level of the sticky edge cursor filter: input register, decision logic, result register.
//
//   Channel   Direction  Carries
//   in_ch     in         new_x, new_y, free_key (one pointer move per request)
//   out_ch    out        override, cursor_x, cursor_y, pinned (one result per move)
//   APB port  in/out     eight 16-bit rectangle edges at byte addresses 0x00 to 0x1C
//
// A move is captured in the input register, decided by one level of compare and add
// logic against the filter state, and then lands in the result register; one move is
// accepted in every cycle while results are taken.
// The filter state is updated in the same edge at which a move enters the result
// register, so the following move already sees it. A stalled result holds the
// result register and the input register; in_ch.ready then drops only once both are
// full. Reset is synchronous and clears the state, the configuration registers and both valid flags.
`default_nettype none
module sticky_edge_cursor_filter (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  sef_in_if.sink                             in_ch,
  sef_out_if.source                          out_ch,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [sef_pkg::ADDR_BITS-1:0] paddr,
  input  wire logic [sef_pkg::DATA_BITS-1:0] pwdata,
  output logic      [sef_pkg::DATA_BITS-1:0] prdata,
  output logic                               pready
);
  import sef_pkg::*;

  cfg_t    cfg;
  move_t   in_r;
  logic    in_v_r;
  result_t out_r;
  logic    out_v_r;
  state_t  state_r;
  state_t  state_nxt;
  result_t res;
  logic    out_free;
  logic    take;
  logic    in_ready;

  sef_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sef_step u_step (
    .cfg    (cfg),
    .mv     (in_r),
    .st     (state_r),
    .res    (res),
    .st_nxt (state_nxt)
  );

  // The result register frees up when it is empty or its result is taken this cycle.
  assign out_free    = !out_v_r || out_ch.ready;
  assign take        = in_v_r && out_free;
  assign in_ready    = !in_v_r || out_free;
  assign in_ch.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      in_r.new_x    <= in_ch.new_x;
      in_r.new_y    <= in_ch.new_y;
      in_r.free_key <= in_ch.free_key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_r <= res;
    end
  end

  // Filter state advances exactly once per move, as the move's result is registered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (take) begin
      state_r <= state_nxt;
    end
  end

  assign out_ch.valid    = out_v_r;
  assign out_ch.override = out_r.override;
  assign out_ch.cursor_x = out_r.cursor_x;
  assign out_ch.cursor_y = out_r.cursor_y;
  assign out_ch.pinned   = out_r.pinned;

  // While pinned the accumulated push always stays below the release threshold.
  a_push_below_force: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.held |-> (state_r.push_total < PUSH_BITS'(HOLD_FORCE)))
    else $error("pinned with push total at or above the release threshold");

  // The pinned flag of the newest result mirrors the held state.
  a_pinned_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> (out_v_r && (out_r.pinned == state_r.held)))
    else $error("result pinned flag disagrees with held state");

  // A pinned result always places the cursor.
  a_pinned_overrides: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.pinned) |-> out_r.override)
    else $error("pinned result without override");

  // An empty result register never blocks a new request.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_v_r |-> in_ready)
    else $error("input stalled with an empty result register");

endmodule
`default_nettype wire
